### rtl/core/cefp_pkg.sv
// Shared constants and types for the cubic extension Frobenius power block.
// No dependencies.
package cefp_pkg;
    localparam int FIELD_BITS = 16;
    localparam int PROD_BITS  = 2 * FIELD_BITS;
    localparam int CNT_BITS   = $clog2(PROD_BITS + 1);

    typedef logic [FIELD_BITS-1:0] fe_t;
    typedef logic [PROD_BITS-1:0]  prod_t;

    // Multiply and reduce operation codes used by the sequencer
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_RED = 2'd1;

    // Top-level states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_BIT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;
endpackage

### rtl/core/cefp_modmul.sv
// Bit-serial modular multiply / reduce unit: r = (a * b) mod m, or r = a mod m.
// Uses cefp_pkg. One bit of a per cycle, MSB first (Horner doubling).
module cefp_modmul (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [1:0]      op,
    input  cefp_pkg::fe_t   a,
    input  cefp_pkg::fe_t   b,
    input  cefp_pkg::fe_t   m,
    output logic            done,
    output cefp_pkg::fe_t   r
);
    import cefp_pkg::*;

    logic [FIELD_BITS-1:0]   a_reg, a_next;
    logic [FIELD_BITS:0]     acc_reg, acc_next;   // stays below m
    logic [FIELD_BITS-1:0]   b_reg, b_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                    run_reg, run_next;
    logic                    done_reg, done_next;
    logic [FIELD_BITS+1:0]   dbl, t1, t2;

    always_comb begin
        a_next    = a_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        dbl = {acc_reg, 1'b0};
        t1  = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
        // acc = 2*acc + bit*b, each step kept below m when b < m (b is not reduced here)
        t2  = t1 + (a_reg[FIELD_BITS-1] ? {2'b00, b_reg} : '0);
        if (t2 >= {2'b00, m}) t2 = t2 - {2'b00, m};
        if (start) begin
            a_next   = a;
            b_next   = (op == OP_RED) ? fe_t'(1) : b;
            acc_next = '0;
            cnt_next = CNT_BITS'(FIELD_BITS);
            run_next = 1'b1;
        end else if (run_reg) begin
            acc_next = t2[FIELD_BITS:0];
            a_next   = {a_reg[FIELD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign r    = acc_reg[FIELD_BITS-1:0];
endmodule

### rtl/core/cubic_extension_frobenius_power.sv
// Frobenius power X^p in F_p[X]/(X^3 + sX - n), top level.
// Uses cefp_pkg and cefp_modmul.
//
// Input channel s_axis: tdata = {n_coef, s_coef}. Result channel m_axis:
// tdata = {coef2, coef1, coef0}, 48 bits. One result per input transaction.
// cfg_we/cfg_wdata write the modulus p (reset 5); write only while idle.
//
// One item is processed at a time. Work is done on one shared bit-serial
// modular multiplier. Each ring product is 9 partial products plus 4
// reduction products (13 operations). With L the bit length of p and w its
// count of one bits, a transaction from input acceptance to m_axis_tvalid
// takes two reductions (s and n mod p) and L+w ring products, with one pass
// through ST_BIT per exponent bit plus one to finish. A modulus below two
// gives an all-zero result in the cycle after acceptance.
// The result is held in an output register; s_axis_tready stays low until the
// receiver takes it, so a stalled receiver stalls the block.
// Reset (aresetn low, synchronous) returns to idle with p = 5.
module cubic_extension_frobenius_power (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] s_coef, [31:16] n_coef
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // [15:0] coef0, [31:16] coef1, [47:32] coef2
);
    import cefp_pkg::*;

    fe_t        mod_reg;
    logic [2:0] st_reg, st_next;
    fe_t        s_reg, n_reg;
    fe_t        acc_reg [3];
    fe_t        base_reg [3];
    fe_t        c_reg [5];
    fe_t        exp_reg;
    logic       phase_reg;         // 0: accum*base, 1: base*base
    logic [3:0] step_reg;          // sequence index in a ring product
    logic       busy_mm;           // operation issued, waiting
    logic       out_v_reg;
    fe_t        out_reg [3];

    logic       mm_start, mm_done;
    logic [1:0] mm_op;
    fe_t        mm_a, mm_b, mm_r;
    fe_t        opa [3];
    fe_t        opb [3];
    fe_t        sum, dif;
    logic [FIELD_BITS:0] sw, dw;

    cefp_modmul u_mm (
        .aclk(aclk), .aresetn(aresetn), .start(mm_start), .op(mm_op),
        .a(mm_a), .b(mm_b), .m(mod_reg), .done(mm_done), .r(mm_r)
    );

    // operands of the current ring product
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            opa[i] = phase_reg ? base_reg[i] : acc_reg[i];
            opb[i] = base_reg[i];
        end
    end

    // schedule: steps 0..8 products a[i]*b[j]; 9: c4*n; 10: c4*s; 11: c3*n; 12: c3*s
    logic [2:0] tgt;
    logic       tsub;
    always_comb begin
        mm_op = OP_MUL;
        mm_a  = '0;
        mm_b  = '0;
        tgt   = '0;
        tsub  = 1'b0;
        unique case (step_reg)
            4'd0:  begin mm_a = opa[0]; mm_b = opb[0]; tgt = 3'd0; end
            4'd1:  begin mm_a = opa[0]; mm_b = opb[1]; tgt = 3'd1; end
            4'd2:  begin mm_a = opa[0]; mm_b = opb[2]; tgt = 3'd2; end
            4'd3:  begin mm_a = opa[1]; mm_b = opb[0]; tgt = 3'd1; end
            4'd4:  begin mm_a = opa[1]; mm_b = opb[1]; tgt = 3'd2; end
            4'd5:  begin mm_a = opa[1]; mm_b = opb[2]; tgt = 3'd3; end
            4'd6:  begin mm_a = opa[2]; mm_b = opb[0]; tgt = 3'd2; end
            4'd7:  begin mm_a = opa[2]; mm_b = opb[1]; tgt = 3'd3; end
            4'd8:  begin mm_a = opa[2]; mm_b = opb[2]; tgt = 3'd4; end
            4'd9:  begin mm_a = c_reg[4]; mm_b = n_reg; tgt = 3'd1; end
            4'd10: begin mm_a = c_reg[4]; mm_b = s_reg; tgt = 3'd2; tsub = 1'b1; end
            4'd11: begin mm_a = c_reg[3]; mm_b = n_reg; tgt = 3'd0; end
            4'd12: begin mm_a = c_reg[3]; mm_b = s_reg; tgt = 3'd1; tsub = 1'b1; end
            default: ;
        endcase
        if (st_reg == ST_PREP) begin
            mm_op = OP_RED;
            mm_a  = step_reg[0] ? n_reg : s_reg;
            mm_b  = '0;
        end
    end

    assign mm_start = !busy_mm && (st_reg == ST_PREP || st_reg == ST_MUL);

    always_comb begin
        sw  = {1'b0, c_reg[tgt]} + {1'b0, mm_r};
        sum = (sw >= {1'b0, mod_reg}) ? fe_t'(sw - {1'b0, mod_reg}) : sw[FIELD_BITS-1:0];
        dw  = {1'b0, c_reg[tgt]} + {1'b0, mod_reg} - {1'b0, mm_r};
        dif = (dw >= {1'b0, mod_reg}) ? fe_t'(dw - {1'b0, mod_reg}) : dw[FIELD_BITS-1:0];
    end

    assign s_axis_tready = (st_reg == ST_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {out_reg[2], out_reg[1], out_reg[0]};

    always_comb begin
        st_next = st_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg   <= fe_t'(5);
            st_reg    <= ST_IDLE;
            out_v_reg <= 1'b0;
            busy_mm   <= 1'b0;
            step_reg  <= '0;
            phase_reg <= 1'b0;
        end else begin
            if (cfg_we) mod_reg <= cfg_wdata;
            if (m_axis_tvalid && m_axis_tready) out_v_reg <= 1'b0;
            if (mm_start) busy_mm <= 1'b1;
            unique case (st_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        s_reg <= s_axis_tdata[15:0];
                        n_reg <= s_axis_tdata[31:16];
                        step_reg <= '0;
                        if (mod_reg < fe_t'(2)) begin
                            for (int i = 0; i < 3; i++) out_reg[i] <= '0;
                            out_v_reg <= 1'b1;
                        end else begin
                            st_reg <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    if (mm_done) begin
                        busy_mm <= 1'b0;
                        if (step_reg[0]) begin
                            n_reg <= mm_r;
                            acc_reg[0] <= fe_t'(1); acc_reg[1] <= '0; acc_reg[2] <= '0;
                            base_reg[0] <= '0; base_reg[1] <= fe_t'(1); base_reg[2] <= '0;
                            exp_reg <= mod_reg;
                            st_reg <= ST_BIT;
                        end else begin
                            s_reg <= mm_r;
                        end
                        step_reg <= step_reg[0] ? 4'd0 : 4'd1;
                    end
                end
                ST_BIT: begin
                    for (int i = 0; i < 5; i++) c_reg[i] <= '0;
                    step_reg <= '0;
                    if (exp_reg == '0) begin
                        out_reg[0] <= acc_reg[0];
                        out_reg[1] <= acc_reg[1];
                        out_reg[2] <= acc_reg[2];
                        out_v_reg <= 1'b1;
                        st_reg <= ST_IDLE;
                    end else begin
                        phase_reg <= !exp_reg[0];
                        st_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (mm_done) begin
                        busy_mm <= 1'b0;
                        if (step_reg == 4'd12) begin
                            step_reg <= '0;
                            for (int i = 0; i < 5; i++) c_reg[i] <= '0;
                            for (int i = 0; i < 3; i++) begin
                                if (phase_reg) base_reg[i] <= (i == 1) ? dif : c_reg[i];
                                else           acc_reg[i]  <= (i == 1) ? dif : c_reg[i];
                            end
                            if (phase_reg) begin
                                exp_reg <= exp_reg >> 1;
                                st_reg  <= ST_BIT;
                            end else begin
                                phase_reg <= 1'b1;
                            end
                        end else begin
                            c_reg[tgt] <= tsub ? dif : sum;
                            step_reg <= step_reg + 4'd1;
                        end
                    end
                end
                default: st_reg <= st_next;
            endcase
        end
    end
endmodule

### sim/tb.sv
// Testbench for cubic_extension_frobenius_power: directed table, then random items
// checked against an in-bench model of X^p in F_p[X]/(X^3 + sX - n). Uses cefp_pkg.
module tb;
    import cefp_pkg::*;

    typedef longint unsigned u64_t;
    typedef u64_t poly_t [3];
    typedef struct packed {
        fe_t c2;
        fe_t c1;
        fe_t c0;
    } coefs_t;
    typedef struct {
        bit     wr_mod;
        fe_t    mod_val;
        fe_t    s_val;
        fe_t    n_val;
        bit     typed;
        coefs_t want;
    } row_t;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int RANDOM_ITEMS   = 925;
    localparam int PHASE_ITEMS    = 25;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    cubic_extension_frobenius_power uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    fe_t    cur_modulus = 16'd5;
    coefs_t frob_queue[$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     idle_mode = 2;      // 0: sender 9%/receiver 64%, 1: swapped, 2: no idling
    int     quiet_cycles = 0;
    int     moduli_used = 0;

    function automatic poly_t ring_product(poly_t a, poly_t b, u64_t s, u64_t n, u64_t m);
        u64_t  c[5];
        poly_t r;
        for (int i = 0; i < 5; i++) c[i] = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                c[i+j] = (c[i+j] + (a[i] * b[j]) % m) % m;
        // fold X^4 = -sX^2 + nX, then X^3 = -sX + n
        c[1] = (c[1] + (c[4] * n) % m) % m;
        c[2] = (c[2] + m - (c[4] * s) % m) % m;
        c[0] = (c[0] + (c[3] * n) % m) % m;
        c[1] = (c[1] + m - (c[3] * s) % m) % m;
        r[0] = c[0];
        r[1] = c[1];
        r[2] = c[2];
        return r;
    endfunction

    function automatic coefs_t frobenius_of(fe_t s_in, fe_t n_in, fe_t p);
        u64_t   m = p;
        u64_t   s, n, e;
        poly_t  acc, sq;
        coefs_t res;
        res = '0;
        if (m < 2) return res;
        s = s_in % m;
        n = n_in % m;
        acc = '{1, 0, 0};
        sq  = '{0, 1, 0};
        e = m;
        for (int k = 0; k < FIELD_BITS && e != 0; k++) begin
            if (e[0]) acc = ring_product(acc, sq, s, n, m);
            sq = ring_product(sq, sq, s, n, m);
            e = e >> 1;
        end
        res.c0 = acc[0][15:0];
        res.c1 = acc[1][15:0];
        res.c2 = acc[2][15:0];
        return res;
    endfunction

    // receiver stalls
    always @(negedge aclk) begin
        case (idle_mode)
            0: m_axis_tready <= ($urandom_range(99) >= 64);
            1: m_axis_tready <= ($urandom_range(99) >= 9);
            default: m_axis_tready <= 1'b1;
        endcase
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            coefs_t got, want;
            got = m_axis_tdata;
            results_seen++;
            if (frob_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
            end else begin
                want = frob_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: p=%0d exp c0=%0d c1=%0d c2=%0d got c0=%0d c1=%0d c2=%0d",
                                 cur_modulus, want.c0, want.c1, want.c2,
                                 got.c0, got.c1, got.c2);
                end
            end
        end
        if (aresetn && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (frob_queue.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_modulus(fe_t p);
        wait_drained();
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_wdata = p;
        @(negedge aclk);
        cfg_we = 1'b0;
        cur_modulus = p;
        moduli_used++;
    endtask

    task automatic send_item(fe_t s_val, fe_t n_val, bit typed, coefs_t want);
        @(negedge aclk);
        if (idle_mode == 0) begin
            while ($urandom_range(99) < 9) @(negedge aclk);
        end else if (idle_mode == 1) begin
            while ($urandom_range(99) < 64) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {n_val, s_val};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        frob_queue.push_back(typed ? want : frobenius_of(s_val, n_val, cur_modulus));
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic fe_t pick_modulus();
        int unsigned r = $urandom_range(99);
        fe_t small_primes [10] = '{5, 7, 11, 13, 17, 31, 61, 101, 127, 251};
        if (r < 70) return small_primes[$urandom_range(9)];
        if (r < 90) return fe_t'($urandom_range(1023));
        if (r < 95) return 16'd65521;
        return fe_t'($urandom);
    endfunction

    row_t directed [] = '{
        // p = 5 after reset; the ring collapses to X^3 = 0 when s = n = 0 mod p
        '{0, 0, 16'd0,     16'd0,     1, '0},
        '{0, 0, 16'd5,     16'd10,    1, '0},
        '{0, 0, 16'd65535, 16'd65535, 1, '0},
        '{0, 0, 16'd1,     16'd2,     0, '0},
        '{0, 0, 16'd4,     16'd3,     0, '0},
        // modulus below two: all-zero result
        '{1, 16'd0, 16'd123,   16'd456,   1, '0},
        '{0, 0,     16'd65535, 16'd0,     1, '0},
        '{1, 16'd1, 16'd0,     16'd65535, 1, '0},
        '{0, 0,     16'd7,     16'd9,     1, '0},
        // even and composite moduli
        '{1, 16'd2,  16'd1,     16'd1,     0, '0},
        '{1, 16'd4,  16'd3,     16'd2,     0, '0},
        '{1, 16'd9,  16'd8,     16'd5,     0, '0},
        // largest prime and all-ones modulus
        '{1, 16'd65521, 16'd65520, 16'd1,     0, '0},
        '{1, 16'd65521, 16'd65521, 16'd65535, 0, '0},
        '{0, 0,         16'd12345, 16'd54321, 0, '0},
        '{1, 16'd65535, 16'd65535, 16'd65534, 0, '0},
        '{0, 0,         16'd0,     16'd1,     0, '0},
        // small prime, reducible cubic X^3 - X (s = -1, n = 0)
        '{1, 16'd7, 16'd6, 16'd0, 0, '0},
        '{0, 0,     16'd3, 16'd5, 0, '0}
    };

    initial begin
        fe_t s_val, n_val;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        idle_mode = 0;
        foreach (directed[i]) begin
            if (directed[i].wr_mod) write_modulus(directed[i].mod_val);
            send_item(directed[i].s_val, directed[i].n_val,
                      directed[i].typed, directed[i].want);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_mode = (i * 3) / RANDOM_ITEMS;
            if (i % PHASE_ITEMS == 0) write_modulus(pick_modulus());
            if (i == PHASE_ITEMS / 2) wait_drained();     // sender holds until all results are back
            if ($urandom_range(1)) begin
                s_val = fe_t'($urandom);
                n_val = fe_t'($urandom);
            end else begin
                s_val = fe_t'($urandom_range(cur_modulus));
                n_val = fe_t'($urandom_range(cur_modulus));
            end
            send_item(s_val, n_val, 1'b0, '0);
        end

        while (frob_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d results over %0d modulus settings, incl. p<2, even, 65521, 65535.",
                 results_seen, moduli_used);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && frob_queue.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### files.f
rtl/core/cefp_pkg.sv
rtl/core/cefp_modmul.sv
rtl/core/cubic_extension_frobenius_power.sv
sim/tb.sv
